/* rtl/tsg_pkg.sv */
package tsg_pkg;

  // result kinds, carried on the result tuser
  localparam logic [1:0] KIND_SPAN = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_RECT = 2'd2;

  // request kinds, carried on the input tuser
  localparam logic REQ_SCAN   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // longest walk per trapezoid
  localparam logic [5:0] MAX_LINES = 6'd63;

  // command queue depth between front and back
  localparam int QUEUE_DEPTH_DEF = 2;

  // empty bounding rectangle
  localparam logic signed [15:0] BOX_HI = 16'sd32767;
  localparam logic signed [15:0] BOX_LO = -16'sd32767;

  localparam int IN_DATA_W  = 152;
  localparam int OUT_DATA_W = 152;

  typedef struct packed {
    logic        finish;
    logic [31:0] x_left;
    logic [31:0] x_right;
    logic [31:0] slope_left;
    logic [31:0] slope_right;
    logic [15:0] line;
    logic [5:0]  count;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_head_t;

endpackage

/* rtl/tsg_front.sv */
module tsg_front #(
  parameter int QUEUE_DEPTH = tsg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tsg_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tuser,
  output tsg_pkg::cmd_head_t             head,
  input  logic                           pop
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  tsg_pkg::cmd_t    q_r [QUEUE_DEPTH];
  tsg_pkg::cmd_t    cmd_in;
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             push;
  logic [5:0]       raw_count;

  assign in_tready = (count_r != CntW'(QUEUE_DEPTH));
  assign push      = in_tvalid && in_tready;
  assign raw_count = in_tdata[149:144];

  // classify and clamp the line count
  always_comb begin
    cmd_in.finish      = (in_tuser == tsg_pkg::REQ_FINISH);
    cmd_in.x_left      = in_tdata[31:0];
    cmd_in.x_right     = in_tdata[63:32];
    cmd_in.slope_left  = in_tdata[95:64];
    cmd_in.slope_right = in_tdata[127:96];
    cmd_in.line        = in_tdata[143:128];
    cmd_in.count       = (raw_count > tsg_pkg::MAX_LINES) ? tsg_pkg::MAX_LINES : raw_count;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign head.valid = (count_r != '0);
  assign head.cmd   = q_r[rd_ptr_r];

endmodule

/* rtl/tsg_back.sv */
module tsg_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tsg_pkg::cmd_head_t              head,
  output logic                            pop,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tsg_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser,
  output logic                            out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_END  = 2'd2;

  // floor(x + 0.5) of a 16.16 value, top end saturated
  function automatic logic signed [15:0] round_edge(input logic [31:0] x);
    logic signed [32:0] s;
    logic signed [16:0] r;
    s = $signed({x[31], x}) + 33'sd32768;
    r = s[32:16];
    if (r == 17'sd32768) begin
      return 16'sd32767;
    end
    return r[15:0];
  endfunction

  logic [1:0]         state_r, state_nxt;
  logic [31:0]        acc_l_r, acc_l_nxt;
  logic [31:0]        acc_r_r, acc_r_nxt;
  logic [31:0]        slope_l_r, slope_l_nxt;
  logic [31:0]        slope_r_r, slope_r_nxt;
  logic [15:0]        line_r, line_nxt;
  logic [5:0]         left_r, left_nxt;
  logic signed [15:0] min_x_r, min_x_nxt;
  logic signed [15:0] min_y_r, min_y_nxt;
  logic signed [15:0] max_x_r, max_x_nxt;
  logic signed [15:0] max_y_r, max_y_nxt;
  logic               bb_pend_r, bb_pend_nxt;
  logic signed [15:0] bb_a_r, bb_a_nxt;
  logic signed [15:0] bb_b_r, bb_b_nxt;
  logic signed [15:0] bb_y_r, bb_y_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         o_kind_r, o_kind_nxt;
  logic               o_last_r, o_last_nxt;
  logic [15:0]        o_line_r, o_line_nxt;
  logic [15:0]        o_start_r, o_start_nxt;
  logic [15:0]        o_end_r, o_end_nxt;
  logic [16:0]        o_bottom_r, o_bottom_nxt;
  logic [31:0]        o_el_r, o_el_nxt;
  logic [31:0]        o_er_r, o_er_nxt;
  logic [15:0]        o_eline_r, o_eline_nxt;

  logic signed [15:0] ra, rb, lo, hi;
  logic               swap, has_span, slot_free;

  assign ra        = round_edge(acc_l_r);
  assign rb        = round_edge(acc_r_r);
  assign swap      = (rb < ra);
  assign lo        = swap ? rb : ra;
  assign hi        = swap ? ra : rb;
  assign has_span  = (lo < hi);
  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt     = state_r;
    acc_l_nxt     = acc_l_r;
    acc_r_nxt     = acc_r_r;
    slope_l_nxt   = slope_l_r;
    slope_r_nxt   = slope_r_r;
    line_nxt      = line_r;
    left_nxt      = left_r;
    min_x_nxt     = min_x_r;
    min_y_nxt     = min_y_r;
    max_x_nxt     = max_x_r;
    max_y_nxt     = max_y_r;
    bb_pend_nxt   = 1'b0;
    bb_a_nxt      = bb_a_r;
    bb_b_nxt      = bb_b_r;
    bb_y_nxt      = bb_y_r;
    out_valid_nxt = out_valid_r && !out_tready;
    o_kind_nxt    = o_kind_r;
    o_last_nxt    = o_last_r;
    o_line_nxt    = o_line_r;
    o_start_nxt   = o_start_r;
    o_end_nxt     = o_end_r;
    o_bottom_nxt  = o_bottom_r;
    o_el_nxt      = o_el_r;
    o_er_nxt      = o_er_r;
    o_eline_nxt   = o_eline_r;
    pop           = 1'b0;

    // grow the rectangle from the span registered in the previous cycle
    if (bb_pend_r) begin
      if (bb_y_r < min_y_r) min_y_nxt = bb_y_r;
      if (bb_y_r > max_y_r) max_y_nxt = bb_y_r;
      if (bb_a_r < min_x_r) min_x_nxt = bb_a_r;
      if (bb_b_r > max_x_r) max_x_nxt = bb_b_r;
    end

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.cmd.finish) begin
            if (slot_free) begin
              pop           = 1'b1;
              out_valid_nxt = 1'b1;
              o_kind_nxt    = tsg_pkg::KIND_RECT;
              o_last_nxt    = 1'b1;
              o_line_nxt    = min_y_r;
              o_start_nxt   = min_x_r;
              o_end_nxt     = max_x_r;
              o_bottom_nxt  = {max_y_r[15], max_y_r} + 17'd1;
              o_el_nxt      = '0;
              o_er_nxt      = '0;
              o_eline_nxt   = '0;
              min_x_nxt     = tsg_pkg::BOX_HI;
              min_y_nxt     = tsg_pkg::BOX_HI;
              max_x_nxt     = tsg_pkg::BOX_LO;
              max_y_nxt     = tsg_pkg::BOX_LO;
            end
          end else begin
            pop         = 1'b1;
            acc_l_nxt   = head.cmd.x_left;
            acc_r_nxt   = head.cmd.x_right;
            slope_l_nxt = head.cmd.slope_left;
            slope_r_nxt = head.cmd.slope_right;
            line_nxt    = head.cmd.line;
            left_nxt    = head.cmd.count;
            state_nxt   = (head.cmd.count == '0) ? ST_END : ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (!has_span || slot_free) begin
          if (has_span) begin
            out_valid_nxt = 1'b1;
            o_kind_nxt    = tsg_pkg::KIND_SPAN;
            o_last_nxt    = 1'b0;
            o_line_nxt    = line_r;
            o_start_nxt   = lo;
            o_end_nxt     = hi;
            o_bottom_nxt  = '0;
            o_el_nxt      = '0;
            o_er_nxt      = '0;
            o_eline_nxt   = '0;
            bb_pend_nxt   = 1'b1;
            bb_a_nxt      = lo;
            bb_b_nxt      = hi;
            bb_y_nxt      = line_r;
          end
          acc_l_nxt = acc_l_r + slope_l_r;
          acc_r_nxt = acc_r_r + slope_r_r;
          line_nxt  = line_r + 16'd1;
          left_nxt  = left_r - 6'd1;
          if (left_r == 6'd1) begin
            state_nxt = ST_END;
          end
        end
      end
      ST_END: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          o_kind_nxt    = tsg_pkg::KIND_END;
          o_last_nxt    = 1'b1;
          o_line_nxt    = '0;
          o_start_nxt   = '0;
          o_end_nxt     = '0;
          o_bottom_nxt  = '0;
          o_el_nxt      = acc_l_r;
          o_er_nxt      = acc_r_r;
          o_eline_nxt   = line_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_l_r     <= '0;
      acc_r_r     <= '0;
      line_r      <= '0;
      left_r      <= '0;
      min_x_r     <= tsg_pkg::BOX_HI;
      min_y_r     <= tsg_pkg::BOX_HI;
      max_x_r     <= tsg_pkg::BOX_LO;
      max_y_r     <= tsg_pkg::BOX_LO;
      bb_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_l_r     <= acc_l_nxt;
      acc_r_r     <= acc_r_nxt;
      line_r      <= line_nxt;
      left_r      <= left_nxt;
      min_x_r     <= min_x_nxt;
      min_y_r     <= min_y_nxt;
      max_x_r     <= max_x_nxt;
      max_y_r     <= max_y_nxt;
      bb_pend_r   <= bb_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slope_l_r  <= slope_l_nxt;
    slope_r_r  <= slope_r_nxt;
    bb_a_r     <= bb_a_nxt;
    bb_b_r     <= bb_b_nxt;
    bb_y_r     <= bb_y_nxt;
    o_kind_r   <= o_kind_nxt;
    o_last_r   <= o_last_nxt;
    o_line_r   <= o_line_nxt;
    o_start_r  <= o_start_nxt;
    o_end_r    <= o_end_nxt;
    o_bottom_r <= o_bottom_nxt;
    o_el_r     <= o_el_nxt;
    o_er_r     <= o_er_nxt;
    o_eline_r  <= o_eline_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = o_kind_r;
  assign out_tlast  = o_last_r;
  assign out_tdata  = {7'd0, o_eline_r, o_er_r, o_el_r, o_bottom_r,
                       o_end_r, o_start_r, o_line_r};

endmodule

/* rtl/trapezoid_span_generator_unit.sv */
// a scan word accepted into an empty unit reaches its first result word through
//   the command queue, the command load and the first scanline; a finish word
//   reaches its rectangle through the command queue and the result register
// the walker works on one command at a time; the queue takes new requests meanwhile
// reset: synchronous, active low; empties the command queue and output register,
//   clears the edge state and sets the bounding rectangle to empty
module trapezoid_span_generator_unit #(
  parameter int QUEUE_DEPTH = tsg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // start_x_left[31:0], start_x_right[63:32], slope_left[95:64],
  // slope_right[127:96], start_line[143:128], line_count[149:144], zero pad
  input  logic [tsg_pkg::IN_DATA_W-1:0]   in_tdata,
  // req_type[0]
  input  logic                            in_tuser,
  // result stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // span_line[15:0], span_start[31:16], span_end[47:32], rect_bottom[64:48],
  // end_x_left[96:65], end_x_right[128:97], end_line[144:129], zero pad
  output logic [tsg_pkg::OUT_DATA_W-1:0]  out_tdata,
  // result_kind[1:0]
  output logic [1:0]                      out_tuser,
  // last_result
  output logic                            out_tlast
);

  tsg_pkg::cmd_head_t head;
  logic               pop;

  // front: takes request words, sorts scan from finish, clamps the count, queues
  tsg_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .head      (head),
    .pop       (pop)
  );

  // back: walks the edges a scanline per cycle unless a span waits on a full result
  // register, keeps the bounding rectangle and drives the registered result port
  tsg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  // the walker only takes commands that the queue holds
  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("command taken from an empty queue");

  // only spans leave with last clear
  a_last_by_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser != tsg_pkg::KIND_SPAN)))
    else $error("last flag does not match result kind");

  // a span is never empty or reversed
  a_span_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == tsg_pkg::KIND_SPAN) |->
      ($signed(out_tdata[31:16]) < $signed(out_tdata[47:32])))
    else $error("span start not below span end");

  // a finish request leaves as a rectangle in the cycle after it is taken
  a_finish_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.cmd.finish) |=> (out_tvalid && out_tuser == tsg_pkg::KIND_RECT))
    else $error("finish request did not produce a rectangle");
`endif

endmodule
